// ----- rtl/core/dcpf_pkg.sv -----
// Shared types and constants for the DNA reverse-complement palindrome finder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dcpf_pkg;

  localparam int BASE_W          = 2;
  localparam int CFG_W           = 6;
  localparam int START_W         = 16;
  localparam int LEN_W           = 6;
  localparam int MAX_PAL_LEN_DEF = 32;
  localparam int MAX_SEQ_LEN_DEF = 65536;

  localparam logic [CFG_W-1:0]  MIN_LEN_RST = 6'd4;
  localparam logic [CFG_W-1:0]  MIN_LEN_LOW = 6'd4;
  localparam logic [BASE_W-1:0] COMP_MASK   = 2'b11;

  // one window slot as handed along the cell chain
  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              valid;
  } dcpf_link_t;

  function automatic logic [BASE_W-1:0] complement(input logic [BASE_W-1:0] b);
    complement = b ^ COMP_MASK;
  endfunction

endpackage

// ----- rtl/core/dna_complement_palindrome_finder.sv -----
// Top level: cell chain over the base window, position counter and result emitter.
// Hit masks are registered in the serializer, or in the holding stage if it is busy.
// Throughput: one base beat per cycle; a base with n hits gives n result beats,
// and the input stalls once the holding stage behind the serializer is full.
// Reset clears window, length flags, position and overflow; min_length returns to 4.
`timescale 1ns / 1ps

module dna_complement_palindrome_finder
  import dcpf_pkg::*;
#(
  parameter int MAX_PAL_LEN = MAX_PAL_LEN_DEF,
  parameter int MAX_SEQ_LEN = MAX_SEQ_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [1:0] base, [7:2] zero
  input  logic               s_axis_tuser_i,   // [0] first_base
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [23:0]        m_axis_tdata_o,   // [15:0] start_pos, [21:16] pal_length
  output logic               m_axis_tlast_o,
  output logic               m_axis_tuser_o    // [0] overflow
);

  localparam int NUM_LENS = MAX_PAL_LEN / 2;
  localparam int SEQ_W    = $clog2(MAX_SEQ_LEN);
  localparam int LW       = LEN_W + 1;

  logic [CFG_W-1:0]    min_q;
  logic [SEQ_W-1:0]    pos_q, pos_eff;
  logic                full_q, full_eff;
  logic                acc, clr;
  logic [BASE_W-1:0]   base;
  logic [LW-1:0]       lo_raw, lo;
  logic [NUM_LENS-1:0] hit, mask;
  dcpf_link_t          link [NUM_LENS+1];
  logic                flag [NUM_LENS+1];
  logic [START_W-1:0]  start;
  logic [LEN_W-1:0]    len;

  assign acc      = s_axis_tvalid_i & s_axis_tready_o;
  assign clr      = s_axis_tuser_i;
  assign base     = s_axis_tdata_i[BASE_W-1:0];
  assign pos_eff  = clr ? '0 : pos_q;
  assign full_eff = full_q & ~clr;

  assign link[0].base  = base;
  assign link[0].valid = 1'b1;
  assign flag[0]       = 1'b1;

  for (genvar k = 0; k < NUM_LENS; k++) begin : g_cell
    dcpf_cell #(
      .FIRST (k == 0)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (acc),
      .clr_i   (clr),
      .base_i  (base),
      .shift_i (link[k]),
      .flag_i  (flag[k]),
      .shift_o (link[k+1]),
      .flag_o  (flag[k+1]),
      .hit_o   (hit[k])
    );
  end

  always_comb begin
    lo_raw = (min_q < MIN_LEN_LOW) ? LW'(MIN_LEN_LOW) : LW'(min_q);
    lo     = (lo_raw + LW'(lo_raw[0])) & ~LW'(1);
  end

  for (genvar k = 0; k < NUM_LENS; k++) begin : g_mask
    localparam int L = 2 * k + 2;
    assign mask[k] = hit[k] & ((L >= 4) && (L < (1 << LW))) & (LW'(L) >= lo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= MIN_LEN_RST;
      pos_q  <= '0;
      full_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
      if (acc) begin
        if (pos_eff == SEQ_W'(MAX_SEQ_LEN - 1)) begin
          pos_q  <= pos_eff;
          full_q <= 1'b1;
        end else begin
          pos_q  <= pos_eff + SEQ_W'(1);
          full_q <= full_eff;
        end
      end
    end
  end

  dcpf_emitter #(
    .NUM_LENS (NUM_LENS),
    .SEQ_W    (SEQ_W)
  ) u_emitter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc & (mask != '0)),
    .mask_i  (mask),
    .idx_i   (pos_eff),
    .ovf_i   (full_eff),
    .ready_o (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .take_i  (m_axis_tready_i),
    .start_o (start),
    .len_o   (len),
    .last_o  (m_axis_tlast_o),
    .ovf_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, len, start};

endmodule

// ----- rtl/core/dcpf_cell.sv -----
// One palindrome chain cell: two window slots (one if FIRST), flag of one even length.
// Depends on dcpf_pkg.
`timescale 1ns / 1ps

module dcpf_cell
  import dcpf_pkg::*;
#(
  parameter bit FIRST = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              clr_i,
  input  logic [BASE_W-1:0] base_i,
  input  dcpf_link_t        shift_i,
  input  logic              flag_i,
  output dcpf_link_t        shift_o,
  output logic              flag_o,
  output logic              hit_o
);

  dcpf_link_t tap_q, tap_d, tap_eff;
  logic       flag_q;

  always_comb begin
    tap_eff       = tap_q;
    tap_eff.valid = tap_q.valid & ~clr_i;
  end

  assign flag_o  = flag_q & ~clr_i;
  assign shift_o = tap_eff;
  assign hit_o   = flag_i & tap_eff.valid & (complement(tap_eff.base) == base_i);

  if (FIRST) begin : g_first
    assign tap_d = shift_i;
  end else begin : g_lead
    dcpf_link_t lead_q, lead_eff;

    always_comb begin
      lead_eff       = lead_q;
      lead_eff.valid = lead_q.valid & ~clr_i;
    end

    assign tap_d = lead_eff;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lead_q <= '0;
      end else if (adv_i) begin
        lead_q <= shift_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q  <= '0;
      flag_q <= 1'b0;
    end else if (adv_i) begin
      tap_q  <= tap_d;
      flag_q <= hit_o;
    end
  end

endmodule

// ----- rtl/core/dcpf_emitter.sv -----
// Result emitter: holding stage and serializer that turn a hit mask into one beat per length.
// Depends on dcpf_pkg.
`timescale 1ns / 1ps

module dcpf_emitter
  import dcpf_pkg::*;
#(
  parameter int NUM_LENS = MAX_PAL_LEN_DEF / 2,
  parameter int SEQ_W    = $clog2(MAX_SEQ_LEN_DEF)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [NUM_LENS-1:0] mask_i,
  input  logic [SEQ_W-1:0]    idx_i,
  input  logic                ovf_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                take_i,
  output logic [START_W-1:0]  start_o,
  output logic [LEN_W-1:0]    len_o,
  output logic                last_o,
  output logic                ovf_o
);

  localparam int KW = $clog2(NUM_LENS);
  localparam int DW = (SEQ_W > START_W) ? SEQ_W : START_W;

  logic [NUM_LENS-1:0] h_mask_q, s_mask_q, s_mask_d, s_rest;
  logic [SEQ_W-1:0]    h_idx_q, s_idx_q, s_idx_d;
  logic                h_ovf_q, s_ovf_q, s_ovf_d;
  logic                h_vq, h_vd, s_vq, s_vd;
  logic                s_free, h_load;
  logic [KW-1:0]       sel;
  logic [DW-1:0]       diff;

  assign s_rest  = s_mask_q & (s_mask_q - NUM_LENS'(1));
  assign last_o  = (s_rest == '0);
  assign s_free  = ~s_vq | (take_i & last_o);
  assign ready_o = ~h_vq | s_free;
  assign h_load  = push_i & (h_vq | ~s_free);

  always_comb begin
    sel = '0;
    for (int k = NUM_LENS - 1; k >= 0; k--) begin
      if (s_mask_q[k]) begin
        sel = KW'(k);
      end
    end
  end

  assign diff    = DW'(s_idx_q) - DW'({sel, 1'b1});
  assign start_o = diff[START_W-1:0];
  assign len_o   = LEN_W'((KW + 2)'({sel, 1'b0}) + (KW + 2)'(2));
  assign ovf_o   = s_ovf_q;
  assign valid_o = s_vq;

  always_comb begin
    s_vd     = s_vq;
    s_mask_d = s_mask_q;
    s_idx_d  = s_idx_q;
    s_ovf_d  = s_ovf_q;
    if (s_free) begin
      if (h_vq) begin
        s_vd     = 1'b1;
        s_mask_d = h_mask_q;
        s_idx_d  = h_idx_q;
        s_ovf_d  = h_ovf_q;
      end else if (push_i) begin
        s_vd     = 1'b1;
        s_mask_d = mask_i;
        s_idx_d  = idx_i;
        s_ovf_d  = ovf_i;
      end else begin
        s_vd = 1'b0;
      end
    end else if (take_i) begin
      s_mask_d = s_rest;
    end
  end

  always_comb begin
    h_vd = h_vq;
    if (h_load) begin
      h_vd = 1'b1;
    end else if (h_vq && s_free) begin
      h_vd = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vq <= 1'b0;
      s_vq <= 1'b0;
    end else begin
      h_vq <= h_vd;
      s_vq <= s_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    s_mask_q <= s_mask_d;
    s_idx_q  <= s_idx_d;
    s_ovf_q  <= s_ovf_d;
    if (h_load) begin
      h_mask_q <= mask_i;
      h_idx_q  <= idx_i;
      h_ovf_q  <= ovf_i;
    end
  end

endmodule
